>>> sv/lli_pkg.sv
// Shared types and constants for the line pair intersection unit.
// No dependencies; imported by lli_line, line_line_intersection_unit and the bench.
`timescale 1ns / 1ps

package lli_pkg;

   typedef enum logic [1:0] {
      STATUS_PARALLEL   = 2'd0,
      STATUS_SINGLE     = 2'd1,
      STATUS_COINCIDENT = 2'd2
   } cross_status_type;

   typedef struct packed {
      logic [31:0] a_x1;
      logic [31:0] a_y1;
      logic [31:0] a_x2;
      logic [31:0] a_y2;
      logic [31:0] b_x1;
      logic [31:0] b_y1;
      logic [31:0] b_x2;
      logic [31:0] b_y2;
   } req_type;

   typedef struct packed {
      cross_status_type cross_status;
      logic [31:0]      cross_x;
      logic [31:0]      cross_y;
      logic             clipped;
   } rsp_type;

   // slope-intercept form of one line, Q32.32
   typedef struct packed {
      logic        vert;
      logic [63:0] m;
      logic [63:0] b;
      logic [31:0] x1;
   } lli_line_type;

   localparam logic [15:0] EPS_RESET = 16'd66;
   localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN   = 64'h8000_0000_0000_0000;
   localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN   = 32'h8000_0000;

endpackage

>>> sv/lli_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a valid bit and a sideband vector alongside; no package use.
`timescale 1ns / 1ps

module lli_div #(
   parameter int NumWidth  = 64,
   parameter int DenWidth  = 32,
   parameter int SideWidth = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [NumWidth-1:0]  in_num,
   input  logic [DenWidth-1:0]  in_den,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [NumWidth-1:0]  out_quo,
   output logic [SideWidth-1:0] out_side
);

   logic                 vld_ff  [0:NumWidth];
   logic [DenWidth-1:0]  rem_ff  [0:NumWidth];
   logic [NumWidth-1:0]  num_ff  [0:NumWidth];
   logic [NumWidth-1:0]  quo_ff  [0:NumWidth];
   logic [DenWidth-1:0]  den_ff  [0:NumWidth];
   logic [SideWidth-1:0] side_ff [0:NumWidth];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      num_ff[0]  <= in_num;
      quo_ff[0]  <= '0;
      den_ff[0]  <= in_den;
      side_ff[0] <= in_side;
   end

   for (genvar i = 0; i < NumWidth; i++) begin : g_stage
      logic [DenWidth:0]   trial;
      logic [DenWidth:0]   diff;
      logic                ge;
      logic [DenWidth-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[i], num_ff[i][NumWidth-1]};
         diff   = trial - {1'b0, den_ff[i]};
         ge     = (trial >= {1'b0, den_ff[i]});
         rem_in = ge ? diff[DenWidth-1:0] : trial[DenWidth-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= rem_in;
         num_ff[i+1]  <= {num_ff[i][NumWidth-2:0], 1'b0};
         quo_ff[i+1]  <= {quo_ff[i][NumWidth-2:0], ge};
         den_ff[i+1]  <= den_ff[i];
         side_ff[i+1] <= side_ff[i];
      end
   end

   assign out_valid = vld_ff[NumWidth];
   assign out_quo   = quo_ff[NumWidth];
   assign out_side  = side_ff[NumWidth];

endmodule

>>> sv/lli_mul.sv
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Carries a valid bit and a sideband vector; no package use.
`timescale 1ns / 1ps

module lli_mul #(
   parameter int SideWidth = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [63:0]          in_a,
   input  logic [63:0]          in_b,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [127:0]         out_prod,
   output logic [SideWidth-1:0] out_side
);

   logic                 vld1_ff, vld2_ff;
   logic [63:0]          ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0]         prod_ff, prod_in;
   logic [SideWidth-1:0] side1_ff, side2_ff;

   always_comb begin
      prod_in = {hh_ff, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ll_ff    <= in_a[31:0] * in_b[31:0];
      lh_ff    <= in_a[31:0] * in_b[63:32];
      hl_ff    <= in_a[63:32] * in_b[31:0];
      hh_ff    <= in_a[63:32] * in_b[63:32];
      side1_ff <= in_side;
      prod_ff  <= prod_in;
      side2_ff <= side1_ff;
   end

   assign out_valid = vld2_ff;
   assign out_prod  = prod_ff;
   assign out_side  = side2_ff;

endmodule

>>> sv/lli_line.sv
// One line from two points to slope and intercept (Q32.32), 71 stages.
// Uses lli_pkg, lli_div and lli_mul.
`timescale 1ns / 1ps

module lli_line import lli_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [31:0]  x1,
   input  logic [31:0]  y1,
   input  logic [31:0]  x2,
   input  logic [31:0]  y2,
   input  logic [15:0]  eps,
   output logic         out_valid,
   output lli_line_type out_line
);

   // stage A: differences
   logic        vld_a_ff;
   logic [32:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [31:0] x1_a_ff, y1_a_ff;

   assign dx_in = {x2[31], x2} - {x1[31], x1};
   assign dy_in = {y2[31], y2} - {y1[31], y1};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      x1_a_ff <= x1;
      y1_a_ff <= y1;
   end

   // magnitudes and vertical test feed the divider input register
   logic [32:0] adx, ady;
   logic        vert, qneg;

   always_comb begin
      adx  = dx_ff[32] ? -dx_ff : dx_ff;
      ady  = dy_ff[32] ? -dy_ff : dy_ff;
      vert = (dx_ff == 33'd0) || (adx < {17'd0, eps});
      qneg = dx_ff[32] ^ dy_ff[32];
   end

   localparam int DivSide = 66;
   logic               div_valid;
   logic [63:0]        div_quo;
   logic [DivSide-1:0] div_side;

   lli_div #(.NumWidth(64), .DenWidth(32), .SideWidth(DivSide)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_a_ff),
      .in_num    ({ady[31:0], 32'd0}),
      .in_den    (adx[31:0]),
      .in_side   ({vert, qneg, x1_a_ff, y1_a_ff}),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   logic        d_vert, d_qneg;
   logic [31:0] d_x1, d_y1;
   assign {d_vert, d_qneg, d_x1, d_y1} = div_side;

   // stage C: saturate slope, magnitudes for the multiply
   logic        vld_c_ff, vert_c_ff, pneg_c_ff, pneg_in;
   logic [63:0] m_c_ff, mmag_c_ff, m_in, mmag_in;
   logic [31:0] x1_c_ff, y1_c_ff, x1mag_c_ff, x1mag_in;

   always_comb begin
      if (!d_qneg) begin
         m_in    = div_quo[63] ? S64_MAX : div_quo;
         mmag_in = m_in;
      end else if (div_quo[63] && (|div_quo[62:0])) begin
         m_in    = S64_MIN;
         mmag_in = S64_MIN;
      end else begin
         m_in    = -div_quo;
         mmag_in = div_quo;
      end
      x1mag_in = d_x1[31] ? -d_x1 : d_x1;
      pneg_in  = d_qneg ^ d_x1[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else begin
         vld_c_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      vert_c_ff  <= d_vert;
      pneg_c_ff  <= pneg_in;
      m_c_ff     <= m_in;
      mmag_c_ff  <= mmag_in;
      x1_c_ff    <= d_x1;
      y1_c_ff    <= d_y1;
      x1mag_c_ff <= x1mag_in;
   end

   localparam int MulSide = 130;
   logic               mul_valid;
   logic [127:0]       mul_prod;
   logic [MulSide-1:0] mul_side;

   lli_mul #(.SideWidth(MulSide)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_c_ff),
      .in_a      (mmag_c_ff),
      .in_b      ({32'd0, x1mag_c_ff}),
      .in_side   ({vert_c_ff, pneg_c_ff, m_c_ff, x1_c_ff, y1_c_ff}),
      .out_valid (mul_valid),
      .out_prod  (mul_prod),
      .out_side  (mul_side)
   );

   logic        p_vert, p_neg;
   logic [63:0] p_m;
   logic [31:0] p_x1, p_y1;
   assign {p_vert, p_neg, p_m, p_x1, p_y1} = mul_side;

   // stage E: b = (y1 << 16) - trunc(m * x1 >> 16)
   logic        vld_e_ff, vert_e_ff;
   logic [81:0] diff_e_ff, diff_in, y1s;
   logic [63:0] m_e_ff;
   logic [31:0] x1_e_ff;

   always_comb begin
      y1s     = {{34{p_y1[31]}}, p_y1, 16'd0};
      diff_in = p_neg ? (y1s + {2'd0, mul_prod[95:16]}) : (y1s - {2'd0, mul_prod[95:16]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_e_ff <= 1'b0;
      end else begin
         vld_e_ff <= mul_valid;
      end
   end

   always_ff @(posedge clock) begin
      vert_e_ff <= p_vert;
      diff_e_ff <= diff_in;
      m_e_ff    <= p_m;
      x1_e_ff   <= p_x1;
   end

   // stage F: saturate intercept
   logic         vld_f_ff;
   lli_line_type line_f_ff, line_in;

   always_comb begin
      line_in.vert = vert_e_ff;
      line_in.m    = m_e_ff;
      line_in.x1   = x1_e_ff;
      if (diff_e_ff[81] && !(&diff_e_ff[80:63])) begin
         line_in.b = S64_MIN;
      end else if (!diff_e_ff[81] && (|diff_e_ff[80:63])) begin
         line_in.b = S64_MAX;
      end else begin
         line_in.b = diff_e_ff[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_f_ff <= 1'b0;
      end else begin
         vld_f_ff <= vld_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      line_f_ff <= line_in;
   end

   assign out_valid = vld_f_ff;
   assign out_line  = line_f_ff;

endmodule

>>> sv/line_line_intersection_unit.sv
// Line pair intersection, slope-intercept form, fully pipelined.
// Throughput: one line pair per cycle; busy is always low. Depth is set by the
// two pipelined dividers (64 and 81 stages) and the two-stage multipliers.
// Reset clears all valid bits and loads vertical_epsilon with 66.
`timescale 1ns / 1ps

module line_line_intersection_unit import lli_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   logic         la_valid, lb_valid;
   lli_line_type la, lb;

   lli_line u_line_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .x1        (req_item.a_x1),
      .y1        (req_item.a_y1),
      .x2        (req_item.a_x2),
      .y2        (req_item.a_y2),
      .eps       (eps_ff),
      .out_valid (la_valid),
      .out_line  (la)
   );

   lli_line u_line_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .x1        (req_item.b_x1),
      .y1        (req_item.b_y1),
      .x2        (req_item.b_x2),
      .y2        (req_item.b_y2),
      .eps       (eps_ff),
      .out_valid (lb_valid),
      .out_line  (lb)
   );

   // T1: slope and intercept differences; both lines run in lockstep
   logic         vld1_ff;
   logic [64:0]  dm_ff, db_ff;
   lli_line_type la1_ff, lb1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= la_valid & lb_valid;
      end
   end

   always_ff @(posedge clock) begin
      dm_ff  <= {la.m[63], la.m} - {lb.m[63], lb.m};
      db_ff  <= {lb.b[63], lb.b} - {la.b[63], la.b};
      la1_ff <= la;
      lb1_ff <= lb;
   end

   logic [64:0]  adm, adb;
   logic [63:0]  em, eb;
   logic [31:0]  vx;
   logic         dm_zero, db_zero, x_eq, xq_neg;

   always_comb begin
      adm     = dm_ff[64] ? -dm_ff : dm_ff;
      adb     = db_ff[64] ? -db_ff : db_ff;
      dm_zero = (dm_ff == 65'd0);
      db_zero = (db_ff == 65'd0);
      x_eq    = (la1_ff.x1 == lb1_ff.x1);
      xq_neg  = dm_ff[64] ^ db_ff[64];
      // a vertical line a is met by line b at a's x; otherwise line a is used
      em      = la1_ff.vert ? lb1_ff.m : la1_ff.m;
      eb      = la1_ff.vert ? lb1_ff.b : la1_ff.b;
      vx      = la1_ff.vert ? la1_ff.x1 : lb1_ff.x1;
   end

   localparam int DivSide = 166;
   logic               div_valid;
   logic [80:0]        div_quo;
   logic [DivSide-1:0] div_side;

   lli_div #(.NumWidth(81), .DenWidth(65), .SideWidth(DivSide)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld1_ff),
      .in_num    ({adb, 16'd0}),
      .in_den    (adm),
      .in_side   ({la1_ff.vert, lb1_ff.vert, dm_zero, db_zero, x_eq, xq_neg, em, eb, vx}),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   logic        q_avert, q_bvert, q_dmzero, q_dbzero, q_xeq, q_neg;
   logic [63:0] q_em, q_eb;
   logic [31:0] q_vx;
   assign {q_avert, q_bvert, q_dmzero, q_dbzero, q_xeq, q_neg, q_em, q_eb, q_vx} = div_side;

   // T3: crossing x in Q48.16, status, operands for y = m*x + b
   logic             vld3_ff, clip3_ff, pneg3_ff, clip_in, pneg_in;
   cross_status_type status3_ff, status_in;
   logic [63:0]      xw3_ff, xmag3_ff, emag3_ff, eb3_ff, xw_in, xmag_in, emag_in;
   logic [31:0]      vxmag;

   always_comb begin
      status_in = STATUS_SINGLE;
      clip_in   = 1'b0;
      xw_in     = 64'd0;
      xmag_in   = 64'd0;
      vxmag     = q_vx[31] ? -q_vx : q_vx;
      if (q_avert && q_bvert) begin
         status_in = q_xeq ? STATUS_COINCIDENT : STATUS_PARALLEL;
      end else if (q_avert || q_bvert) begin
         xw_in   = {{32{q_vx[31]}}, q_vx};
         xmag_in = {32'd0, vxmag};
      end else if (q_dmzero) begin
         status_in = q_dbzero ? STATUS_COINCIDENT : STATUS_PARALLEL;
      end else if (!q_neg) begin
         if (|div_quo[80:63]) begin
            clip_in = 1'b1;
            xw_in   = S64_MAX;
         end else begin
            xw_in   = div_quo[63:0];
         end
         xmag_in = xw_in;
      end else begin
         if ((|div_quo[80:64]) || (div_quo[63] && (|div_quo[62:0]))) begin
            clip_in = 1'b1;
            xw_in   = S64_MIN;
            xmag_in = S64_MIN;
         end else begin
            xw_in   = -div_quo[63:0];
            xmag_in = div_quo[63:0];
         end
      end
      emag_in = q_em[63] ? -q_em : q_em;
      pneg_in = q_em[63] ^ xw_in[63];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      status3_ff <= status_in;
      clip3_ff   <= clip_in;
      pneg3_ff   <= pneg_in;
      xw3_ff     <= xw_in;
      xmag3_ff   <= xmag_in;
      emag3_ff   <= emag_in;
      eb3_ff     <= q_eb;
   end

   localparam int MulSide = 132;
   logic               mul_valid;
   logic [127:0]       mul_prod;
   logic [MulSide-1:0] mul_side;

   lli_mul #(.SideWidth(MulSide)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld3_ff),
      .in_a      (emag3_ff),
      .in_b      (xmag3_ff),
      .in_side   ({status3_ff, clip3_ff, pneg3_ff, eb3_ff, xw3_ff}),
      .out_valid (mul_valid),
      .out_prod  (mul_prod),
      .out_side  (mul_side)
   );

   logic [1:0]  p_status;
   logic        p_clip, p_neg;
   logic [63:0] p_eb, p_xw;
   assign {p_status, p_clip, p_neg, p_eb, p_xw} = mul_side;

   // T4: t = m*x + (b << 16), clamp x to 32 bits
   logic         vld4_ff, clip4_ff, clip4_in;
   logic [1:0]   status4_ff;
   logic [127:0] t4_ff, t_in, ebs;
   logic [31:0]  x4_ff, x_in;

   always_comb begin
      ebs  = {{48{p_eb[63]}}, p_eb, 16'd0};
      t_in = p_neg ? (ebs - mul_prod) : (ebs + mul_prod);
      clip4_in = p_clip;
      if (p_xw[63] && !(&p_xw[62:31])) begin
         x_in     = S32_MIN;
         clip4_in = 1'b1;
      end else if (!p_xw[63] && (|p_xw[62:31])) begin
         x_in     = S32_MAX;
         clip4_in = 1'b1;
      end else begin
         x_in     = p_xw[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else begin
         vld4_ff <= mul_valid;
      end
   end

   always_ff @(posedge clock) begin
      status4_ff <= p_status;
      clip4_ff   <= clip4_in;
      t4_ff      <= t_in;
      x4_ff      <= x_in;
   end

   // T5: y magnitude, truncated toward zero by the >> 32
   logic         vld5_ff, clip5_ff, tneg5_ff;
   logic [1:0]   status5_ff;
   logic [127:0] tmag;
   logic [95:0]  tq5_ff;
   logic [31:0]  x5_ff;

   assign tmag = t4_ff[127] ? -t4_ff : t4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else begin
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      status5_ff <= status4_ff;
      clip5_ff   <= clip4_ff;
      tneg5_ff   <= t4_ff[127];
      tq5_ff     <= tmag[127:32];
      x5_ff      <= x4_ff;
   end

   // T6: clamp y and form the result beat
   logic    vld6_ff, y_over;
   logic [31:0] y_val;
   rsp_type rsp6_ff, rsp_in;

   always_comb begin
      if (tneg5_ff) begin
         y_over = (|tq5_ff[95:32]) || (tq5_ff[31] && (|tq5_ff[30:0]));
         y_val  = y_over ? S32_MIN : -tq5_ff[31:0];
      end else begin
         y_over = |tq5_ff[95:31];
         y_val  = y_over ? S32_MAX : tq5_ff[31:0];
      end
      rsp_in.cross_status = cross_status_type'(status5_ff);
      if (cross_status_type'(status5_ff) == STATUS_SINGLE) begin
         rsp_in.cross_x = x5_ff;
         rsp_in.cross_y = y_val;
         rsp_in.clipped = clip5_ff | y_over;
      end else begin
         rsp_in.cross_x = 32'd0;
         rsp_in.cross_y = 32'd0;
         rsp_in.clipped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else begin
         vld6_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp6_ff <= rsp_in;
   end

   assign rsp_valid = vld6_ff;
   assign rsp_item  = rsp6_ff;

endmodule

>>> verif/tb.sv
// Self-checking bench for line_line_intersection_unit: a directed table, then random
// line pairs, scored against a Q32.32 slope-intercept predictor. Depends on lli_pkg.
`timescale 1ns / 1ps

module tb;
   import lli_pkg::*;

   typedef logic signed [127:0] wide_t;

   typedef struct {
      req_type pair;
      bit      typed;
      rsp_type want;
   } vector_type;

   typedef struct {
      bit    vert;
      wide_t m;
      wide_t b;
   } slope_line_type;

   localparam int LATENCY = 160;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   rsp_type     expected_points[$];
   vector_type  table_rows[$];
   logic [15:0] eps_model;
   bit          sat_seen;
   int          fail_count;

   line_line_intersection_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic wide_t saturate(wide_t v, wide_t lo, wide_t hi);
      if (v < lo) begin
         sat_seen = 1'b1;
         return lo;
      end
      if (v > hi) begin
         sat_seen = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic wide_t s64_lo();
      return -(wide_t'(1) <<< 63);
   endfunction

   function automatic wide_t s64_hi();
      return (wide_t'(1) <<< 63) - 1;
   endfunction

   function automatic slope_line_type fit_line(logic [31:0] x1, logic [31:0] y1,
                                               logic [31:0] x2, logic [31:0] y2);
      slope_line_type l;
      wide_t dx, dy, adx, prod;
      dx  = wide_t'($signed(x2)) - wide_t'($signed(x1));
      dy  = wide_t'($signed(y2)) - wide_t'($signed(y1));
      adx = dx < 0 ? -dx : dx;
      l.m = 0;
      l.b = 0;
      l.vert = (dx == 0) || (adx < wide_t'(eps_model));
      if (!l.vert) begin
         l.m  = saturate((dy <<< 32) / dx, s64_lo(), s64_hi());
         prod = l.m * wide_t'($signed(x1));
         l.b  = saturate((wide_t'($signed(y1)) <<< 16) - prod / 128'sd65536,
                         s64_lo(), s64_hi());
      end
      return l;
   endfunction

   function automatic wide_t y_at(slope_line_type l, wide_t x);
      wide_t t;
      t = l.m * x + (l.b <<< 16);
      return saturate(t / (wide_t'(1) <<< 32), -(wide_t'(1) <<< 31),
                      (wide_t'(1) <<< 31) - 1);
   endfunction

   function automatic rsp_type predict_crossing(req_type p);
      slope_line_type la, lb;
      rsp_type r;
      wide_t x, y, dm, db;
      la = fit_line(p.a_x1, p.a_y1, p.a_x2, p.a_y2);
      lb = fit_line(p.b_x1, p.b_y1, p.b_x2, p.b_y2);
      sat_seen = 1'b0;   // slope and intercept saturation does not count
      x = 0;
      y = 0;
      r.cross_status = STATUS_SINGLE;
      if (la.vert && lb.vert) begin
         r.cross_status = (p.a_x1 == p.b_x1) ? STATUS_COINCIDENT : STATUS_PARALLEL;
      end else if (la.vert) begin
         x = wide_t'($signed(p.a_x1));
         y = y_at(lb, x);
      end else if (lb.vert) begin
         x = wide_t'($signed(p.b_x1));
         y = y_at(la, x);
      end else begin
         dm = la.m - lb.m;
         db = lb.b - la.b;
         if (dm == 0) begin
            r.cross_status = (db == 0) ? STATUS_COINCIDENT : STATUS_PARALLEL;
         end else begin
            x = saturate((db <<< 16) / dm, s64_lo(), s64_hi());
            y = y_at(la, x);
            x = saturate(x, -(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1);
         end
      end
      r.cross_x = x[31:0];
      r.cross_y = y[31:0];
      r.clipped = sat_seen;
      return r;
   endfunction

   // ---------------- result checking ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            rsp_type w;
            w = expected_points.pop_front();
            if (rsp_item.cross_status !== w.cross_status) begin
               $error("cross_status exp %0d got %0d", w.cross_status, rsp_item.cross_status);
               fail_count++;
            end
            if (rsp_item.cross_x !== w.cross_x) begin
               $error("cross_x exp %h got %h", w.cross_x, rsp_item.cross_x);
               fail_count++;
            end
            if (rsp_item.cross_y !== w.cross_y) begin
               $error("cross_y exp %h got %h", w.cross_y, rsp_item.cross_y);
               fail_count++;
            end
            if (rsp_item.clipped !== w.clipped) begin
               $error("clipped exp %0d got %0d", w.clipped, rsp_item.clipped);
               fail_count++;
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic req_type pack_pair(logic [31:0] ax1, logic [31:0] ay1, logic [31:0] ax2,
                                         logic [31:0] ay2, logic [31:0] bx1, logic [31:0] by1,
                                         logic [31:0] bx2, logic [31:0] by2);
      req_type p;
      p = '{ax1, ay1, ax2, ay2, bx1, by1, bx2, by2};
      return p;
   endfunction

   function automatic logic [31:0] near_coord();
      return 32'($signed($urandom_range(32'h80000)) - 32'sh40000);
   endfunction

   function automatic req_type random_pair();
      req_type p;
      logic [31:0] d;
      int kind;
      kind = $urandom_range(7);
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      case (kind)
         0: ;  // full-range noise
         1, 2: begin
            p = pack_pair(near_coord(), near_coord(), near_coord(), near_coord(),
                          near_coord(), near_coord(), near_coord(), near_coord());
         end
         3: begin  // near-vertical line around the epsilon boundary
            p.a_x2 = p.a_x1 + 32'($urandom_range(int'(eps_model) + 2)) *
                     ($urandom_range(1) ? 1 : -1);
            if ($urandom_range(1)) p.b_x2 = p.b_x1 + 32'($urandom_range(3));
         end
         4: begin  // parallel copy, shifted in y
            p = pack_pair(near_coord(), near_coord(), near_coord(), near_coord(),
                          0, 0, 0, 0);
            d = $urandom_range(1) ? 32'($urandom_range(3)) : near_coord();
            p.b_x1 = p.a_x1;
            p.b_x2 = p.a_x2;
            p.b_y1 = p.a_y1 + d;
            p.b_y2 = p.a_y2 + d;
         end
         5: begin  // same line, points maybe swapped
            p.a_x1 = near_coord();
            p.a_y1 = near_coord();
            p.a_x2 = near_coord();
            p.a_y2 = near_coord();
            if ($urandom_range(1)) p.b_x1 = p.a_x1; else p.b_x1 = p.a_x2;
            p.b_y1 = (p.b_x1 == p.a_x1) ? p.a_y1 : p.a_y2;
            p.b_x2 = (p.b_x1 == p.a_x1) ? p.a_x2 : p.a_x1;
            p.b_y2 = (p.b_x1 == p.a_x1) ? p.a_y2 : p.a_y1;
         end
         6: begin  // both vertical, x equal or close
            p.a_x2 = p.a_x1;
            p.b_x1 = p.a_x1 + 32'($urandom_range(1));
            p.b_x2 = p.b_x1;
         end
         default: begin  // nearly parallel steep lines, far crossing
            p.a_x1 = 0;
            p.a_x2 = 32'd1 + 32'($urandom_range(int'(eps_model) + 4));
            p.b_x1 = 0;
            p.b_x2 = p.a_x2 + 32'd1;
         end
      endcase
      return p;
   endfunction

   task automatic send_pair(req_type p, bit typed, rsp_type want);
      int gap;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= p;
      do @(posedge clock); while (busy);
      expected_points.push_back(typed ? want : predict_crossing(p));
   endtask

   task automatic drain_and_idle();
      if (start) begin
         start <= 1'b0;
         @(posedge clock);
      end
      wait (expected_points.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_epsilon(logic [15:0] v);
      drain_and_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      eps_model    = v;
   endtask

   function automatic rsp_type typed_result(cross_status_type s, logic [31:0] x,
                                            logic [31:0] y, logic c);
      rsp_type r;
      r = '{s, x, y, c};
      return r;
   endfunction

   initial begin
      logic [15:0] eps_steps[5];
      rsp_type none;
      fail_count  = 0;
      eps_model   = EPS_RESET;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      none        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      table_rows.push_back('{pack_pair(0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 32'h10000, 0),
                             1, typed_result(STATUS_SINGLE, 32'h8000, 32'h8000, 0)});
      table_rows.push_back('{pack_pair(5, 0, 5, 9, 5, 3, 5, 7), 1,
                             typed_result(STATUS_COINCIDENT, 0, 0, 0)});
      table_rows.push_back('{pack_pair(5, 0, 5, 9, 32'h30000, 3, 32'h30000, 7), 1,
                             typed_result(STATUS_PARALLEL, 0, 0, 0)});
      table_rows.push_back('{pack_pair(0, 0, 32'h20000, 32'h10000, 0, 0, 32'h20000, 32'h10000),
                             1, typed_result(STATUS_COINCIDENT, 0, 0, 0)});
      table_rows.push_back('{pack_pair(0, 0, 32'h20000, 32'h10000, 0, 1, 32'h20000, 32'h10001),
                             1, typed_result(STATUS_PARALLEL, 0, 0, 0)});
      table_rows.push_back('{pack_pair(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                       32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF),
                             0, none});
      table_rows.push_back('{pack_pair(32'h80000000, 0, 32'h80000000, 1, 0, 32'h80000000,
                                       32'h7FFFFFFF, 32'h7FFFFFFF), 0, none});
      table_rows.push_back('{pack_pair(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1,
                                       32'h7FFFFFFF), 0, none});
      table_rows.push_back('{pack_pair(0, 0, 65, 1, 0, 0, 66, 1), 0, none});
      table_rows.push_back('{pack_pair(0, 0, 32'h7FFFFFFF, 1, 0, 32'h10000, 32'h7FFFFFFF, 2),
                             0, none});
      table_rows.push_back('{pack_pair(0, 0, 1, 32'h7FFFFFFF, 0, 0, 32'hFFFFFFFF, 32'h7FFFFFFF),
                             0, none});
      table_rows.push_back('{pack_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                       0, 0, 0, 0), 1,
                             typed_result(STATUS_PARALLEL, 0, 0, 0)});
      foreach (table_rows[i]) send_pair(table_rows[i].pair, table_rows[i].typed,
                                        table_rows[i].want);

      // zero epsilon: only exact zero dx is vertical
      write_epsilon(16'd0);
      send_pair(pack_pair(7, 0, 7, 5, 0, 0, 1, 0), 0, none);
      send_pair(pack_pair(0, 0, 1, 1, 0, 0, 32'hFFFFFFFF, 1), 0, none);

      eps_steps = '{16'hFFFF, 16'd0, EPS_RESET, 16'd1, 16'($urandom)};
      foreach (eps_steps[k]) begin
         write_epsilon(eps_steps[k]);
         repeat (280) send_pair(random_pair(), 0, none);
      end

      drain_and_idle();
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
